@@ hdl/cqmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Circular queue with match count: shared definitions
// Request and result payloads, command codes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cqmc_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int COUNT_W       = 4;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_COUNT   = 2'd2;

    localparam logic [COUNT_W-1:0]       COUNT_MAX = 4'd15;
    localparam logic signed [WORD_W-1:0] FAIL_WORD = -32'sd1;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [WORD_W-1:0] operand_word;
    } item_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        logic                     failed;
        logic [COUNT_W-1:0]       match_count;
    } item_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEQ,
        ST_CNT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic deq_capture;
        logic cnt_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       empty;
        logic       full;
        logic       walk_done;
    } ctrl_status_t;

endpackage

@@ hdl/cqmc_dpath.sv @@
// ----------------------------------------------------------------------------
// Circular queue with match count: datapath
// Entry memory, head, tail and walk pointers, the match comparator with its
// saturating counter, and the result register.
// ----------------------------------------------------------------------------
module cqmc_dpath #(
    parameter int DEPTH = cqmc_pkg::DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cqmc_pkg::item_in_t      in_data,
    input  cqmc_pkg::ctrl_cmd_t     cmd,
    output cqmc_pkg::ctrl_status_t  status,
    output cqmc_pkg::item_out_t     out_data
);
    import cqmc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == LAST_SLOT) ? '0 : AW'(p + 1'b1);
        return r;
    endfunction

    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [AW-1:0]            walk_reg, walk_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic signed [WORD_W-1:0] opd_reg, opd_next;
    logic signed [WORD_W-1:0] rd_data_reg;
    logic signed [WORD_W-1:0] res_word_reg, res_word_next;
    logic                     res_failed_reg, res_failed_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    item_out_t                out_data_reg;

    logic                     wr_en;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     empty;
    logic                     full;

    assign empty = (head_reg == tail_reg);
    assign full  = (next_slot(tail_reg) == head_reg);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        walk_next       = walk_reg;
        cmd_next        = cmd_reg;
        opd_next        = opd_reg;
        res_word_next   = res_word_reg;
        res_failed_next = res_failed_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        if (cmd.accept)
        begin
            cmd_next = in_data.command;
            opd_next = in_data.operand_word;
        end

        if (cmd.exec)
        begin
            res_word_next   = '0;
            res_failed_next = 1'b0;
            count_next      = '0;
            case (cmd_reg)
                CMD_ENQUEUE:
                begin
                    if (full)
                    begin
                        res_failed_next = 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        tail_next = next_slot(tail_reg);
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (empty)
                    begin
                        res_failed_next = 1'b1;
                        res_word_next   = FAIL_WORD;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = head_reg;
                        head_next = next_slot(head_reg);
                    end
                end
                CMD_COUNT:
                begin
                    if (!empty)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = head_reg;
                        walk_next = next_slot(head_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.deq_capture)
        begin
            res_word_next = rd_data_reg;
        end

        if (cmd.cnt_step)
        begin
            if ((rd_data_reg == opd_reg) && (count_reg != COUNT_MAX))
            begin
                count_next = COUNT_W'(count_reg + 1'b1);
            end
            if (walk_reg != tail_reg)
            begin
                rd_en     = 1'b1;
                rd_addr   = walk_reg;
                walk_next = next_slot(walk_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg       <= walk_next;
        cmd_reg        <= cmd_next;
        opd_reg        <= opd_next;
        res_word_reg   <= res_word_next;
        res_failed_reg <= res_failed_next;
        count_reg      <= count_next;
        if (cmd.load_out)
        begin
            out_data_reg.read_word   <= res_word_reg;
            out_data_reg.failed      <= res_failed_reg;
            out_data_reg.match_count <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= opd_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status.command   = cmd_reg;
    assign status.empty     = empty;
    assign status.full      = full;
    assign status.walk_done = (walk_reg == tail_reg);
    assign out_data         = out_data_reg;

    a_full_enq_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (cmd_reg == CMD_ENQUEUE) && full |=> $stable(tail_reg))
        else $error("Enqueue on a full queue moved the tail pointer.");

    a_empty_deq_fails: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (cmd_reg == CMD_DEQUEUE) && empty
        |=> res_failed_reg && (res_word_reg == FAIL_WORD) && $stable(head_reg))
        else $error("Dequeue on an empty queue did not report failure.");

    a_pointers_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= LAST_SLOT) && (tail_reg <= LAST_SLOT))
        else $error("A queue pointer left the range of the entry memory.");

endmodule

@@ hdl/cqmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Circular queue with match count: controller
// Sequences one request at a time through execute, memory read or walk,
// and hand-over to the result register.
// ----------------------------------------------------------------------------
module cqmc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  cqmc_pkg::ctrl_status_t status,
    output cqmc_pkg::ctrl_cmd_t    cmd
);
    import cqmc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if ((status.command == CMD_DEQUEUE) && !status.empty)
                begin
                    state_next = ST_DEQ;
                end
                else if ((status.command == CMD_COUNT) && !status.empty)
                begin
                    state_next = ST_CNT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DEQ:
            begin
                cmd.deq_capture = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_CNT:
            begin
                cmd.cnt_step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_executes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EXEC)
        else $error("An accepted request was not executed next.");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_valid_reg && !out_ready
        |=> (state_reg == ST_FINISH) && out_valid_reg)
        else $error("A result overwrote one still waiting to be taken.");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CNT) && status.walk_done |=> state_reg == ST_FINISH)
        else $error("The count walk ran past the tail.");

endmodule

@@ hdl/circular_queue_with_match_count_core.sv @@
// ----------------------------------------------------------------------------
// Circular queue with match count: top level
// A circular queue of signed 32-bit words holding DEPTH-1 entries, with
// enqueue, dequeue and count-matching-entries requests.
//
// Requests arrive on in_valid/in_ready with in_data, and each request gives
// exactly one result on out_valid/out_ready with out_data. A request is
// taken only while the controller is idle; the result register lets a new
// request be taken while the previous result still waits for the receiver.
// Enqueue, failed dequeue and unused codes go from acceptance through the
// execute and finish states to the result; a successful dequeue adds a
// capture state after the registered memory read. A count adds a walk step
// per stored entry, since one comparator walks the memory one entry per cycle
// from head to tail; the next request waits until this result is loaded.
// When the receiver stalls, the finished result is held in the output
// register and the controller waits before loading the next one.
// Reset empties the queue by clearing both pointers; the entry memory needs
// no clearing pass and no request is refused after reset.
// ----------------------------------------------------------------------------
module circular_queue_with_match_count_core #(
    parameter int DEPTH = cqmc_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cqmc_pkg::item_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cqmc_pkg::item_out_t out_data
);
    import cqmc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    cqmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cqmc_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
